### src/cas_pkg.sv
// Shared types and constants for the cave smoothing step block.
// Used by every module of the block but cas_ram; depends on nothing else.
package cas_pkg;

    localparam int MAX_WIDTH_DEF  = 128;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int CFG_W_BITS  = 8;
    localparam int CFG_H_BITS  = 7;
    localparam int LIMIT_BITS  = 4;
    localparam int COUNT_BITS  = 4;
    localparam int ROW_BITS    = 6;
    localparam int COL_BITS    = 7;

    localparam int APB_DATA_BITS  = 32;
    localparam int REG_ADDR_BITS  = 4;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = 24;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - (1 + COUNT_BITS + ROW_BITS + COL_BITS);

    localparam int OQ_DEPTH     = 4;
    localparam int OQ_PTR_BITS  = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_BITS  = $clog2(OQ_DEPTH + 1);

    localparam logic [CFG_W_BITS-1:0] RST_FRAME_WIDTH  = 8'd70;
    localparam logic [CFG_H_BITS-1:0] RST_FRAME_HEIGHT = 7'd30;
    localparam logic [LIMIT_BITS-1:0] RST_BIRTH_LIMIT  = 4'd4;
    localparam logic [LIMIT_BITS-1:0] RST_DEATH_LIMIT  = 4'd3;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_BIRTH_LIMIT  = 2'd2,
        REG_DEATH_LIMIT  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] birth;
        logic [LIMIT_BITS-1:0] death;
    } t_limits;

    // One column shift into the window, plus the position of the result it may produce.
    typedef struct packed {
        logic                shift;
        logic                emit;
        logic                start;
        logic                alive;
        logic                row_one;
        logic                col_one;
        logic                m_top;
        logic                m_bot;
        logic                m_left;
        logic                m_right;
        logic                last;
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
    } t_shift_cmd;

    typedef struct packed {
        logic                  next_alive;
        logic [COUNT_BITS-1:0] count;
        logic [ROW_BITS-1:0]   row;
        logic [COL_BITS-1:0]   col;
        logic                  last;
    } t_result;

endpackage

### src/cas_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module cas_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/cas_ctrl.sv
// Frame sequencer: raster counters, result bookkeeping and line buffer addressing.
// Uses cas_pkg for the command struct and field widths.
module cas_ctrl #(
    parameter int MAX_WIDTH  = cas_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cas_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic                            i_req_type,
    input  logic                            i_cell_alive,
    input  logic [cas_pkg::CFG_W_BITS-1:0]  i_frame_width,
    input  logic [cas_pkg::CFG_H_BITS-1:0]  i_frame_height,
    output cas_pkg::t_shift_cmd             o_cmd,
    output logic [$clog2(MAX_WIDTH)-1:0]    o_addr
);
    import cas_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH + 3);

    logic          r_busy, n_busy;
    logic [WW-1:0] r_lat_w, n_lat_w;
    logic [HW-1:0] r_lat_h, n_lat_h;
    logic [AW-1:0] r_in_col, n_in_col;
    logic [HW-1:0] r_in_row, n_in_row;
    logic [PW-1:0] r_pend, n_pend;
    logic [AW-1:0] r_emit_col, n_emit_col;
    logic [HW-1:0] r_emit_row, n_emit_row;

    logic          start, active, filling, is_cell, is_drain, flushed, shift, emit;
    logic [WW-1:0] clamp_w, eff_w, col_inc, ecol_inc;
    logic [HW-1:0] clamp_h, eff_h, erow_next;
    logic [AW-1:0] in_col_c, ecol_c, next_col;
    logic [HW-1:0] in_row_c, erow_c;
    logic [PW-1:0] pend_c, pend_inc;
    logic          col_wrap, ecol_wrap;

    always_comb begin
        start  = !r_busy && !i_req_type;
        active = r_busy || start;

        if (i_frame_width == '0) begin
            clamp_w = WW'(1);
        end else if (int'(i_frame_width) > MAX_WIDTH) begin
            clamp_w = WW'(MAX_WIDTH);
        end else begin
            clamp_w = WW'(i_frame_width);
        end
        if (i_frame_height == '0) begin
            clamp_h = HW'(1);
        end else if (int'(i_frame_height) > MAX_HEIGHT) begin
            clamp_h = HW'(MAX_HEIGHT);
        end else begin
            clamp_h = HW'(i_frame_height);
        end

        eff_w    = start ? clamp_w : r_lat_w;
        eff_h    = start ? clamp_h : r_lat_h;
        in_col_c = start ? '0 : r_in_col;
        in_row_c = start ? '0 : r_in_row;
        pend_c   = start ? '0 : r_pend;
        ecol_c   = start ? '0 : r_emit_col;
        erow_c   = start ? '0 : r_emit_row;

        filling  = in_row_c < eff_h;
        is_cell  = active && filling && !i_req_type;
        is_drain = active && !filling && (pend_c != '0);
        flushed  = active && !filling && (pend_c == '0);
        shift    = is_cell || is_drain;
        pend_inc = pend_c + PW'(1);
        emit     = is_drain || (is_cell && (pend_inc > (PW'(eff_w) + PW'(1))));

        col_inc   = WW'(in_col_c) + WW'(1);
        col_wrap  = col_inc >= eff_w;
        next_col  = col_wrap ? '0 : AW'(col_inc);
        ecol_inc  = WW'(ecol_c) + WW'(1);
        ecol_wrap = ecol_inc >= eff_w;
        erow_next = ecol_wrap ? (erow_c + HW'(1)) : erow_c;

        n_busy     = r_busy;
        n_lat_w    = r_lat_w;
        n_lat_h    = r_lat_h;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_pend     = r_pend;
        n_emit_col = r_emit_col;
        n_emit_row = r_emit_row;

        if (i_accept && active) begin
            n_lat_w    = eff_w;
            n_lat_h    = eff_h;
            n_in_col   = shift ? next_col : in_col_c;
            n_in_row   = (is_cell && col_wrap) ? (in_row_c + HW'(1)) : in_row_c;
            n_pend     = pend_c + PW'(is_cell) - PW'(emit);
            n_emit_col = emit ? (ecol_wrap ? '0 : AW'(ecol_inc)) : ecol_c;
            n_emit_row = emit ? erow_next : erow_c;
            n_busy     = !flushed && !(emit && (erow_next >= eff_h));
        end

        o_cmd.shift   = i_accept && shift;
        o_cmd.emit    = i_accept && emit;
        o_cmd.start   = i_accept && start;
        o_cmd.alive   = i_cell_alive;
        o_cmd.row_one = eff_h == HW'(1);
        o_cmd.col_one = ecol_c == AW'(1);
        o_cmd.m_top   = erow_c == '0;
        o_cmd.m_bot   = erow_c == (eff_h - HW'(1));
        o_cmd.m_left  = ecol_c == '0;
        o_cmd.m_right = WW'(ecol_c) == (eff_w - WW'(1));
        o_cmd.last    = (erow_c == (eff_h - HW'(1))) && (WW'(ecol_c) == (eff_w - WW'(1)));
        o_cmd.row     = ROW_BITS'(erow_c);
        o_cmd.col     = COL_BITS'(ecol_c);

        // A one-row frame emits one beat early, so its drain reads one column ahead.
        o_addr = (is_drain && (eff_h == HW'(1))) ? next_col : in_col_c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_lat_w    <= '0;
            r_lat_h    <= '0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_pend     <= '0;
            r_emit_col <= '0;
            r_emit_row <= '0;
        end else begin
            r_busy     <= n_busy;
            r_lat_w    <= n_lat_w;
            r_lat_h    <= n_lat_h;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_pend     <= n_pend;
            r_emit_col <= n_emit_col;
            r_emit_row <= n_emit_row;
        end
    end

endmodule

### src/cas_window.sv
// Window stage: line buffer read-modify-write with forwarding, 3x3 window,
// neighbour count and smoothing rule. Uses cas_pkg types.
module cas_window #(
    parameter int MAX_WIDTH = cas_pkg::MAX_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  cas_pkg::t_shift_cmd            i_cmd,
    input  logic [$clog2(MAX_WIDTH)-1:0]   i_addr,
    input  logic [1:0]                     i_rd_data,
    input  cas_pkg::t_limits               i_limits,
    output logic                           o_we,
    output logic [$clog2(MAX_WIDTH)-1:0]   o_waddr,
    output logic [1:0]                     o_wdata,
    output logic                           o_res_vld,
    output cas_pkg::t_result               o_res,
    output logic                           o_s1_emit
);
    import cas_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    t_shift_cmd      r_s1;
    logic [AW-1:0]   r_s1_addr;
    logic            r_fwd;
    logic [1:0]      r_fwd_data;
    logic [2:0]      r_win_m, r_win_n;
    logic            r_first;

    logic [1:0]            rd_eff, wdata;
    logic [2:0]            col_new, left, center, right, rowm, lv, rv;
    logic [7:0]            nb;
    logic [COUNT_BITS-1:0] cnt;

    always_comb begin
        rd_eff  = r_fwd ? r_fwd_data : i_rd_data;
        col_new = {rd_eff[1], rd_eff[0], r_s1.alive};
        wdata   = {rd_eff[0], r_s1.alive};

        left   = r_win_m;
        center = r_win_n;
        right  = col_new;
        if (r_s1.row_one && r_s1.m_left) begin
            center[1] = r_first;
        end
        if (r_s1.row_one && r_s1.col_one) begin
            left[1] = r_first;
        end

        rowm = {r_s1.m_top, 1'b0, r_s1.m_bot};
        lv   = left | {3{r_s1.m_left}} | rowm;
        rv   = right | {3{r_s1.m_right}} | rowm;
        nb   = {lv, rv, center[2] | r_s1.m_top, center[0] | r_s1.m_bot};

        cnt = '0;
        for (int i = 0; i < 8; i++) begin
            cnt = cnt + COUNT_BITS'(nb[i]);
        end

        o_res.next_alive = center[1] ? (cnt >= i_limits.death) : (cnt > i_limits.birth);
        o_res.count      = cnt;
        o_res.row        = r_s1.row;
        o_res.col        = r_s1.col;
        o_res.last       = r_s1.last;
    end

    assign o_we      = r_s1.shift;
    assign o_waddr   = r_s1_addr;
    assign o_wdata   = wdata;
    assign o_res_vld = r_s1.shift && r_s1.emit;
    assign o_s1_emit = r_s1.emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= '0;
            r_fwd   <= 1'b0;
            r_win_m <= '0;
            r_win_n <= '0;
        end else begin
            r_s1  <= i_cmd;
            r_fwd <= i_cmd.shift && r_s1.shift && (i_addr == r_s1_addr);
            if (r_s1.shift) begin
                r_win_m <= r_win_n;
                r_win_n <= col_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr  <= i_addr;
        r_fwd_data <= wdata;
        if (r_s1.start) begin
            r_first <= r_s1.alive;
        end
    end

endmodule

### src/cas_outq.sv
// Small result queue in front of the output stream.
// Uses cas_pkg for the result type and queue depth.
module cas_outq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    input  cas_pkg::t_result                i_res,
    input  logic                            i_ready,
    output logic                            o_valid,
    output cas_pkg::t_result                o_res,
    output logic [cas_pkg::OQ_CNT_BITS-1:0] o_count
);
    import cas_pkg::*;

    t_result                r_mem [OQ_DEPTH];
    logic [OQ_PTR_BITS-1:0] r_wr, r_rd;
    logic [OQ_CNT_BITS-1:0] r_cnt;
    logic                   pop;

    assign o_valid = r_cnt != '0;
    assign pop     = o_valid && i_ready;
    assign o_res   = r_mem[r_rd];
    assign o_count = r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + OQ_PTR_BITS'(1);
            end
            if (pop) begin
                r_rd <= r_rd + OQ_PTR_BITS'(1);
            end
            r_cnt <= r_cnt + OQ_CNT_BITS'(i_push) - OQ_CNT_BITS'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_res;
        end
    end

endmodule

### src/cave_automaton_smoothing_step.sv
// Top level of the cave smoothing step: register port, sequencer, line buffer RAM,
// window stage and result queue. Depends on cas_pkg and cas_* modules but cas_checker.
//
// Usage: cells of the old frame arrive on s_axis in raster order, one per beat, with
// tuser low; tuser high marks a drain beat. The frame size is taken from the registers
// when a frame's first cell arrives; the limits are used as they stand. The result for
// a cell leaves on m_axis when the beat one row and one cell later is accepted, or
// during the drain; tlast marks the frame's final cell. After the last cell, as many
// drain beats as results are still owed (frame width plus one at most) flush the frame.
// Drain beats that come while no result is owed are swallowed.
// A released result is registered in the window stage, then in the result queue.
// Throughput: one beat per cycle unless tready is low; the line buffer RAM is read and
// written once per beat, with forwarding when one column is hit on consecutive beats.
// Up to four results are held or in flight; when the receiver stalls and that many are
// held or in flight, s_axis_tready falls until a result is taken.
// Reset clears the frame state and the result queue and restores the register
// defaults; the line buffer contents are left as they are, and entries the current
// frame has not yet written reach only window positions masked as frame border.
module cave_automaton_smoothing_step #(
    parameter int MAX_WIDTH  = cas_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = cas_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [cas_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // [0] cell_alive
    input  logic                                s_axis_tuser,  // [0] req_type
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] next_alive, [4:1] neighbour_count, [10:5] out_row, [17:11] out_col
    output logic [cas_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    output logic                                m_axis_tlast,  // frame_last
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cas_pkg::REG_ADDR_BITS-1:0]   paddr,
    input  logic [cas_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [cas_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import cas_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    logic [CFG_W_BITS-1:0] r_frame_width;
    logic [CFG_H_BITS-1:0] r_frame_height;
    logic [LIMIT_BITS-1:0] r_birth_limit;
    logic [LIMIT_BITS-1:0] r_death_limit;

    t_reg_idx               reg_idx;
    logic                   cfg_wr;
    logic                   accept;
    t_shift_cmd             cmd;
    logic [AW-1:0]          rd_addr;
    logic [1:0]             rd_data;
    logic                   lb_we;
    logic [AW-1:0]          lb_waddr;
    logic [1:0]             lb_wdata;
    t_limits                limits;
    logic                   res_vld;
    t_result                res;
    t_result                oq_res;
    logic                   s1_emit;
    logic [OQ_CNT_BITS-1:0] oq_count;
    logic [OQ_CNT_BITS:0]   occ;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[REG_ADDR_BITS-1:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_birth_limit  <= RST_BIRTH_LIMIT;
            r_death_limit  <= RST_DEATH_LIMIT;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= pwdata[CFG_W_BITS-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= pwdata[CFG_H_BITS-1:0];
                REG_BIRTH_LIMIT:  r_birth_limit  <= pwdata[LIMIT_BITS-1:0];
                REG_DEATH_LIMIT:  r_death_limit  <= pwdata[LIMIT_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(r_frame_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(r_frame_height);
            REG_BIRTH_LIMIT:  prdata = APB_DATA_BITS'(r_birth_limit);
            REG_DEATH_LIMIT:  prdata = APB_DATA_BITS'(r_death_limit);
        endcase
    end

    assign occ           = (OQ_CNT_BITS+1)'(oq_count) + (OQ_CNT_BITS+1)'(s1_emit);
    assign s_axis_tready = occ < (OQ_CNT_BITS+1)'(OQ_DEPTH);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign limits.birth  = r_birth_limit;
    assign limits.death  = r_death_limit;

    cas_ctrl #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (s_axis_tuser),
        .i_cell_alive   (s_axis_tdata[0]),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_cmd          (cmd),
        .o_addr         (rd_addr)
    );

    cas_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (lb_we),
        .i_waddr (lb_waddr),
        .i_wdata (lb_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    cas_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_addr    (rd_addr),
        .i_rd_data (rd_data),
        .i_limits  (limits),
        .o_we      (lb_we),
        .o_waddr   (lb_waddr),
        .o_wdata   (lb_wdata),
        .o_res_vld (res_vld),
        .o_res     (res),
        .o_s1_emit (s1_emit)
    );

    cas_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_vld),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (oq_res),
        .o_count (oq_count)
    );

    assign m_axis_tdata = {{OUT_PAD_BITS{1'b0}}, oq_res.col, oq_res.row, oq_res.count,
                           oq_res.next_alive};
    assign m_axis_tlast = oq_res.last;

endmodule

### src/cas_checker.sv
// Port-level checks for the cave smoothing step, bound to the top level.
// Depends on cas_pkg and cave_automaton_smoothing_step.
module cas_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [cas_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,
    input logic                                m_axis_tlast
);
    import cas_pkg::*;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[4:1] <= 4'd8))
        else $error("neighbour count above eight");

    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> (m_axis_tdata[4:1] >= 4'd5))
        else $error("final cell sees fewer than five border neighbours");

    a_first_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[17:5] == 13'd0) |-> (m_axis_tdata[4:1] >= 4'd5))
        else $error("top-left cell sees fewer than five border neighbours");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind cave_automaton_smoothing_step cas_checker u_cas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
